@@ sv/block_window_blend_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Block window blend unit assertion macros
// Shared property shorthands for the blend unit. They expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BLOCK_WINDOW_BLEND_UNIT_DEFINES_SVH
`define BLOCK_WINDOW_BLEND_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BBU_ASSERT_NOW(label, cond_a, cond_b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond_a) |-> (cond_b)) else $error(msg);

// Next-cycle implication.
`define BBU_ASSERT_NEXT(label, cond_a, cond_b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond_a) |=> (cond_b)) else $error(msg);

`endif

@@ sv/bbu_pkg.sv @@
// ----------------------------------------------------------------------------
// Block window blend package
// Widths, command codes, register indexes, size clamps and shared structs.
// ----------------------------------------------------------------------------
package bbu_pkg;

	localparam int MAX_BLOCK_WIDTH  = 64;
	localparam int MAX_BLOCK_HEIGHT = 64;
	localparam int MAX_LINE_WIDTH   = 4096;
	localparam int MAX_LINE_COUNT   = 4096;

	localparam int BW_BITS   = 7;
	localparam int LW_BITS   = 13;
	localparam int POS_BITS  = 12;
	localparam int BPOS_BITS = 6;
	localparam int IDX_BITS  = 12;
	localparam int W_BITS    = 9;
	localparam int PIX_BITS  = 8;
	localparam int TABLE_DEPTH = MAX_BLOCK_WIDTH * MAX_BLOCK_HEIGHT;

	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 13;

	localparam logic [W_BITS-1:0] WEIGHT_ONE = 9'd256;
	localparam int WEIGHT_SHIFT = 8;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_BLEND = 1'b1
	} cmd_t;

	localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_WIDTH  = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_HEIGHT = 8'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH   = 8'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_COUNT   = 8'd3;

	typedef struct packed {
		logic [BW_BITS-1:0] bw;
		logic [BW_BITS-1:0] bh;
		logic [LW_BITS-1:0] lw;
		logic [LW_BITS-1:0] lc;
	} sizes_t;

	typedef struct packed {
		logic                full;
		logic                last;
		logic [IDX_BITS-1:0] index;
	} pos_info_t;

	// Zero acts as one, anything above the bound acts as the bound.
	function automatic logic [BW_BITS-1:0] clamp_block(input logic [BW_BITS-1:0] v,
			input logic [BW_BITS-1:0] hi);
		logic [BW_BITS-1:0] r;
		if (v == '0) begin
			r = BW_BITS'(1);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [LW_BITS-1:0] clamp_line(input logic [LW_BITS-1:0] v,
			input logic [LW_BITS-1:0] hi);
		logic [LW_BITS-1:0] r;
		if (v == '0) begin
			r = LW_BITS'(1);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [W_BITS-1:0] sat_weight(input logic [W_BITS-1:0] v);
		return (v > WEIGHT_ONE) ? WEIGHT_ONE : v;
	endfunction

endpackage

@@ sv/block_window_blend_unit.sv @@
// ----------------------------------------------------------------------------
// Block window blend unit
// Overlapped block window blending of one picture plane, streaming in and out.
// ----------------------------------------------------------------------------
// The unit takes one input transfer per clock whenever the output register is
// empty or being drained, so a steady stream runs at one pixel pair per cycle.
// Each transfer is either a weight load (tuser = 0) or a blend (tuser = 1);
// a load gives no output, a blend gives exactly one. Output valid is
// registered: the input register captures at the transfer edge, then the
// weight RAM read (registered port, one read per cycle) and the output
// register follow. A load followed directly by a blend of the same table
// entry sees the new weight. The table is not cleared at reset: load every
// entry the plane will use before the first blend. Sizes are to be written
// by the user on the cfg channel only while the stream is idle; the unit
// does not enforce it. Zero acts as one and values above the maximum sizes saturate.
// ----------------------------------------------------------------------------
`include "block_window_blend_unit_defines.svh"

module block_window_blend_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// slave stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [11:0] weight_index, [20:12] weight_value, [28:21] source_pixel,
	// [36:29] shifted_pixel, [39:37] zero
	input  logic [39:0]                        s_tdata,
	// [0] command
	input  logic                               s_tuser,
	// master stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [7:0] blended_pixel
	output logic [7:0]                         m_tdata,
	output logic                               m_tlast,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bbu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [bbu_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import bbu_pkg::*;

	// clamped size registers
	sizes_t sizes_q;

	// input stage
	logic                valid_s1;
	cmd_t                cmd_s1;
	logic [IDX_BITS-1:0] widx_s1;
	logic [W_BITS-1:0]   wval_s1;
	logic [PIX_BITS-1:0] src_s1, sh_s1;

	// weight read stage
	logic                valid_s2;
	logic [PIX_BITS-1:0] src_s2, sh_s2;
	logic                full_s2, last_s2;

	logic                en;
	logic                step;
	logic                ram_we;
	logic [W_BITS-1:0]   weight_rd;
	logic [PIX_BITS-1:0] pixel;
	pos_info_t           info;

	// The whole pipe advances together whenever the output slot is free.
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;
	assign step      = en && valid_s1 && (cmd_s1 == CMD_BLEND);
	assign ram_we    = en && valid_s1 && (cmd_s1 == CMD_LOAD);

	// Configuration: clamp on write, ignore unknown indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sizes_q.bw <= BW_BITS'(8);
			sizes_q.bh <= BW_BITS'(8);
			sizes_q.lw <= LW_BITS'(720);
			sizes_q.lc <= LW_BITS'(576);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BLOCK_WIDTH: begin
					sizes_q.bw <= clamp_block(cfg_data[BW_BITS-1:0], BW_BITS'(MAX_BLOCK_WIDTH));
				end
				REG_BLOCK_HEIGHT: begin
					sizes_q.bh <= clamp_block(cfg_data[BW_BITS-1:0],
						BW_BITS'(MAX_BLOCK_HEIGHT));
				end
				REG_LINE_WIDTH: begin
					sizes_q.lw <= clamp_line(cfg_data[LW_BITS-1:0], LW_BITS'(MAX_LINE_WIDTH));
				end
				REG_LINE_COUNT: begin
					sizes_q.lc <= clamp_line(cfg_data[LW_BITS-1:0], LW_BITS'(MAX_LINE_COUNT));
				end
				default: begin
				end
			endcase
		end
	end

	// Input register: capture each transfer, drop the slot when nothing arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= cmd_t'(s_tuser);
			widx_s1 <= s_tdata[11:0];
			wval_s1 <= s_tdata[20:12];
			src_s1  <= s_tdata[28:21];
			sh_s1   <= s_tdata[36:29];
		end
	end

	// Raster position and full-block test for the item in the input stage.
	bbu_position u_position (
		.clk    (clk),
		.arst_n (arst_n),
		.sizes  (sizes_q),
		.step   (step),
		.info   (info)
	);

	// Loads write from the input stage; blends read in the same slot, so a
	// load always lands before any later blend reads.
	bbu_weight_ram u_weight_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (widx_s1),
		.wdata (sat_weight(wval_s1)),
		.re    (en),
		.raddr (info.index),
		.rdata (weight_rd)
	);

	// Weight read stage: only blends travel on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1 && (cmd_s1 == CMD_BLEND);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			src_s2  <= src_s1;
			sh_s2   <= sh_s1;
			full_s2 <= info.full;
			last_s2 <= info.last;
		end
	end

	bbu_blend u_blend (
		.src     (src_s2),
		.shifted (sh_s2),
		.weight  (weight_rd),
		.full    (full_s2),
		.pixel   (pixel)
	);

	// Output register: hold while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			m_tdata <= pixel;
			m_tlast <= last_s2;
		end
	end

	`BBU_ASSERT_NEXT(a_load_no_result, en && valid_s1 && (cmd_s1 == CMD_LOAD), !valid_s2,
		"weight load reached the blend stage")
	`BBU_ASSERT_NEXT(a_blend_to_output, en && valid_s2, m_tvalid,
		"blend in read stage did not reach the output")
	`BBU_ASSERT_NOW(a_output_source, $rose(m_tvalid), $past(valid_s2),
		"output valid without a blend behind it")

endmodule

@@ sv/bbu_weight_ram.sv @@
// ----------------------------------------------------------------------------
// Weight table RAM
// One write port and one registered read port, no reset on the contents.
// ----------------------------------------------------------------------------
module bbu_weight_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [bbu_pkg::IDX_BITS-1:0] waddr,
	input  logic [bbu_pkg::W_BITS-1:0]   wdata,
	input  logic                         re,
	input  logic [bbu_pkg::IDX_BITS-1:0] raddr,
	output logic [bbu_pkg::W_BITS-1:0]   rdata
);
	import bbu_pkg::*;

	logic [W_BITS-1:0] mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/bbu_position.sv @@
// ----------------------------------------------------------------------------
// Raster position tracker
// Column, row and in-block counters; full-block test and weight index.
// ----------------------------------------------------------------------------
module bbu_position (
	input  logic               clk,
	input  logic               arst_n,
	input  bbu_pkg::sizes_t    sizes,
	input  logic               step,
	output bbu_pkg::pos_info_t info
);
	import bbu_pkg::*;

	logic [POS_BITS-1:0]  column_q, row_q;
	logic [BPOS_BITS-1:0] cib_q, rib_q;

	logic                 col_wrap, row_wrap;
	logic [POS_BITS-1:0]  col_w, row_w;
	logic [BPOS_BITS-1:0] cib_w, rib_w;
	logic                 full_x, full_y;
	logic [LW_BITS:0]     span_x, span_y;
	logic [LW_BITS-1:0]   col_inc, row_inc;
	logic [BW_BITS-1:0]   cib_inc, rib_inc;
	logic                 line_end, plane_end;
	logic [POS_BITS-1:0]  column_d, row_d;
	logic [BPOS_BITS-1:0] cib_d, rib_d;

	always_comb begin
		// counters left past a shrunken bound restart first
		col_wrap = LW_BITS'(column_q) >= sizes.lw;
		row_wrap = LW_BITS'(row_q) >= sizes.lc;
		col_w = col_wrap ? '0 : column_q;
		cib_w = col_wrap ? '0 : cib_q;
		row_w = row_wrap ? '0 : row_q;
		rib_w = row_wrap ? '0 : rib_q;

		span_x = (LW_BITS+1)'(col_w) - (LW_BITS+1)'(cib_w) + (LW_BITS+1)'(sizes.bw);
		span_y = (LW_BITS+1)'(row_w) - (LW_BITS+1)'(rib_w) + (LW_BITS+1)'(sizes.bh);
		full_x = (BW_BITS'(cib_w) < sizes.bw) && (POS_BITS'(cib_w) <= col_w)
			&& (span_x <= (LW_BITS+1)'(sizes.lw));
		full_y = (BW_BITS'(rib_w) < sizes.bh) && (POS_BITS'(rib_w) <= row_w)
			&& (span_y <= (LW_BITS+1)'(sizes.lc));

		col_inc = LW_BITS'(col_w) + LW_BITS'(1);
		cib_inc = BW_BITS'(cib_w) + BW_BITS'(1);
		row_inc = LW_BITS'(row_w) + LW_BITS'(1);
		rib_inc = BW_BITS'(rib_w) + BW_BITS'(1);
		line_end  = col_inc >= sizes.lw;
		plane_end = row_inc >= sizes.lc;

		column_d = col_inc[POS_BITS-1:0];
		cib_d    = (cib_inc >= sizes.bw) ? '0 : cib_inc[BPOS_BITS-1:0];
		row_d    = row_w;
		rib_d    = rib_w;
		if (line_end) begin
			column_d = '0;
			cib_d    = '0;
			row_d    = row_inc[POS_BITS-1:0];
			rib_d    = (rib_inc >= sizes.bh) ? '0 : rib_inc[BPOS_BITS-1:0];
			if (plane_end) begin
				row_d = '0;
				rib_d = '0;
			end
		end

		info.full  = full_x && full_y;
		info.last  = line_end && plane_end;
		info.index = {rib_w, cib_w};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
			cib_q    <= '0;
			rib_q    <= '0;
		end else if (step) begin
			column_q <= column_d;
			row_q    <= row_d;
			cib_q    <= cib_d;
			rib_q    <= rib_d;
		end
	end

endmodule

@@ sv/bbu_blend.sv @@
// ----------------------------------------------------------------------------
// Pixel blend datapath
// Weighted mix of source and shifted bytes, or source pass-through.
// ----------------------------------------------------------------------------
module bbu_blend (
	input  logic [bbu_pkg::PIX_BITS-1:0] src,
	input  logic [bbu_pkg::PIX_BITS-1:0] shifted,
	input  logic [bbu_pkg::W_BITS-1:0]   weight,
	input  logic                         full,
	output logic [bbu_pkg::PIX_BITS-1:0] pixel
);
	import bbu_pkg::*;

	localparam int PROD_BITS = PIX_BITS + W_BITS;

	logic [W_BITS-1:0]    inv_weight;
	logic [PROD_BITS-1:0] prod_src, prod_sh, mix;

	always_comb begin
		inv_weight = WEIGHT_ONE - weight;
		prod_src   = PROD_BITS'(src) * PROD_BITS'(weight);
		prod_sh    = PROD_BITS'(shifted) * PROD_BITS'(inv_weight);
		mix        = prod_src + prod_sh;
		pixel      = full ? mix[WEIGHT_SHIFT +: PIX_BITS] : src;
	end

endmodule

@@ test/tb_block_window_blend_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block window blend unit testbench
// Streams weight loads and pixel pairs through the unit. Several plane and
// block geometries are set up, the extremes among them. An in-bench model of
// the raster walk and the weight table predicts every output pixel and its
// end-of-plane flag.
// ----------------------------------------------------------------------------
module tb_block_window_blend_unit;

	import bbu_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned SETTLE_CYCLES = 8;     // settle time after the last result
	localparam int unsigned SHOWN_ERRORS  = 10;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_FIRST = 8'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LAST  = 8'hFF;

	// one input transfer: a weight load or a pixel pair to blend
	typedef struct packed {
		cmd_t                cmd;
		logic [IDX_BITS-1:0] idx;
		logic [W_BITS-1:0]   wv;
		logic [PIX_BITS-1:0] src;
		logic [PIX_BITS-1:0] sh;
		logic                hold_for_drain;  // launch only once no result is pending
	} pair_item_t;

	typedef struct packed {
		logic [PIX_BITS-1:0] pix;
		logic                eop;
	} blend_result_t;

	// raster position: plane column and row, position inside the block
	typedef struct packed {
		logic [31:0] col;
		logic [31:0] row;
		logic [31:0] cib;
		logic [31:0] rib;
	} raster_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [39:0]               s_tdata = '0;
	logic                      s_tuser = 1'b0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [7:0]                m_tdata;
	logic                      m_tlast;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	block_window_blend_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Register values as written; only changed while the stream is idle, so the
	// stimulus planner and the predictor share them.
	sizes_t cur_sizes;

	pair_item_t    feed_q[$];
	blend_result_t blend_expect_q[$];
	pair_item_t    on_bus;

	// predictor state, advanced on accepted transfers
	logic [W_BITS-1:0] weight_mem [TABLE_DEPTH];
	raster_t           blend_pos = '0;

	// planner state, advanced as items are queued
	raster_t plan_pos = '0;
	bit      plan_loaded [TABLE_DEPTH];

	bit          idle_en = 1'b1;
	int unsigned send_gap = 0;
	int unsigned sink_stall = 0;
	int unsigned err_cnt = 0;
	int unsigned cycle_cnt = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int unsigned bounded(input int unsigned v, input int unsigned hi);
		if (v == 0) return 1;
		return (v > hi) ? hi : v;
	endfunction

	// Work out one blend step: wrap counters left beyond new bounds, decide
	// whether the pixel lies in a full block, then advance the raster.
	function automatic raster_t raster_step(input raster_t p, input sizes_t s,
			output logic full, output logic [IDX_BITS-1:0] tidx, output logic eop);
		int unsigned bw, bh, lw, lc;
		raster_t n;
		bw = bounded(s.bw, MAX_BLOCK_WIDTH);
		bh = bounded(s.bh, MAX_BLOCK_HEIGHT);
		lw = bounded(s.lw, MAX_LINE_WIDTH);
		lc = bounded(s.lc, MAX_LINE_COUNT);
		n = p;
		if (n.col >= lw) begin
			n.col = 0;
			n.cib = 0;
		end
		if (n.row >= lc) begin
			n.row = 0;
			n.rib = 0;
		end
		full = (n.cib < bw) && (n.cib <= n.col) && (n.col - n.cib + bw <= lw) &&
			(n.rib < bh) && (n.rib <= n.row) && (n.row - n.rib + bh <= lc);
		tidx = IDX_BITS'((n.rib * MAX_BLOCK_WIDTH + n.cib) % TABLE_DEPTH);
		eop = 1'b0;
		n.col = n.col + 1;
		n.cib = n.cib + 1;
		if (n.cib >= bw) n.cib = 0;
		if (n.col >= lw) begin
			n.col = 0;
			n.cib = 0;
			n.row = n.row + 1;
			n.rib = n.rib + 1;
			if (n.rib >= bh) n.rib = 0;
			if (n.row >= lc) begin
				n.row = 0;
				n.rib = 0;
				eop = 1'b1;
			end
		end
		return n;
	endfunction

	// mostly no gap, some short ones, a few long ones
	function automatic int unsigned draw_gap();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 10) return 0;
		if (r < 17) return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	function automatic logic [W_BITS-1:0] draw_weight();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 7) return W_BITS'($urandom_range(0, 256));
		if (r == 7) return WEIGHT_ONE;
		if (r == 8) return '0;
		return W_BITS'($urandom_range(257, 511));
	endfunction

	// Block sizes: mostly small, some up to the bound, a few zero or above it.
	// Random upper bits beyond the register width get dropped by the unit.
	function automatic logic [CFG_DATA_BITS-1:0] draw_block_size();
		int unsigned r;
		logic [BW_BITS-1:0] v;
		r = $urandom_range(0, 19);
		if (r < 14) v = BW_BITS'($urandom_range(1, 8));
		else if (r < 17) v = BW_BITS'($urandom_range(9, MAX_BLOCK_WIDTH));
		else if (r == 17) v = '0;
		else v = BW_BITS'($urandom_range(MAX_BLOCK_WIDTH + 1, 127));
		return {(CFG_DATA_BITS - BW_BITS)'($urandom), v};
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] draw_line_size(input int unsigned small_hi);
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 14) return CFG_DATA_BITS'($urandom_range(1, small_hi));
		if (r < 17) return CFG_DATA_BITS'($urandom_range(small_hi + 1, 300));
		if (r == 17) return '0;
		if (r == 18) return CFG_DATA_BITS'(MAX_LINE_WIDTH);
		return CFG_DATA_BITS'($urandom_range(MAX_LINE_WIDTH + 1, 8191));
	endfunction

	task automatic flag_error(input string msg);
		err_cnt++;
		if (err_cnt <= SHOWN_ERRORS) $display("ERROR: %s", msg);
	endtask

	task automatic queue_load(input logic [IDX_BITS-1:0] idx, input logic [W_BITS-1:0] wv,
			input logic hold);
		pair_item_t it;
		it.cmd = CMD_LOAD;
		it.idx = idx;
		it.wv = wv;
		it.src = PIX_BITS'($urandom);
		it.sh = PIX_BITS'($urandom);
		it.hold_for_drain = hold;
		feed_q.push_back(it);
		plan_loaded[idx] = 1'b1;
	endtask

	// Queue a pixel pair; if it lies in a full block, load its weight first
	// when the table entry it will read has never been written.
	task automatic queue_blend(input logic [PIX_BITS-1:0] src, input logic [PIX_BITS-1:0] sh,
			input logic hold);
		raster_t nxt;
		logic full, eop;
		logic [IDX_BITS-1:0] tidx;
		pair_item_t it;
		nxt = raster_step(plan_pos, cur_sizes, full, tidx, eop);
		if (full && !plan_loaded[tidx]) queue_load(tidx, draw_weight(), hold);
		it.cmd = CMD_BLEND;
		it.idx = IDX_BITS'($urandom);
		it.wv = W_BITS'($urandom);
		it.src = src;
		it.sh = sh;
		it.hold_for_drain = hold;
		feed_q.push_back(it);
		plan_pos = nxt;
	endtask

	// Wait until every queued item is accepted and every result has arrived,
	// then let the pipeline settle since loads give no result. Sample between
	// edges so the driver and monitor updates of the last edge have landed.
	task automatic wait_drained();
		do @(negedge clk);
		while (feed_q.size() != 0 || s_tvalid || blend_expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		// transfer taken at this edge
		case (idx)
			REG_BLOCK_WIDTH: cur_sizes.bw = val[BW_BITS-1:0];
			REG_BLOCK_HEIGHT: cur_sizes.bh = val[BW_BITS-1:0];
			REG_LINE_WIDTH: cur_sizes.lw = val[LW_BITS-1:0];
			REG_LINE_COUNT: cur_sizes.lc = val[LW_BITS-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_sizes(input logic [CFG_DATA_BITS-1:0] bw, input logic [CFG_DATA_BITS-1:0] bh,
			input logic [CFG_DATA_BITS-1:0] lw, input logic [CFG_DATA_BITS-1:0] lc);
		write_reg(REG_BLOCK_WIDTH, bw);
		write_reg(REG_BLOCK_HEIGHT, bh);
		write_reg(REG_LINE_WIDTH, lw);
		write_reg(REG_LINE_COUNT, lc);
	endtask

	// ------------------------------------------------------------------------
	// Driver: present queued items on the slave stream. Hold an item until it
	// is taken; insert random gaps after each transfer while idling is on.
	// The predictor runs here on every accepted transfer.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : pair_driver
		raster_t nxt;
		logic full, eop;
		logic [IDX_BITS-1:0] tidx;
		int unsigned w, mix;
		blend_result_t res;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= CMD_LOAD;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (on_bus.cmd == CMD_LOAD) begin
					// saturate weights above one
					weight_mem[on_bus.idx] = (on_bus.wv > WEIGHT_ONE) ? WEIGHT_ONE : on_bus.wv;
				end else begin
					nxt = raster_step(blend_pos, cur_sizes, full, tidx, eop);
					if (full) begin
						w = weight_mem[tidx];
						mix = (on_bus.src * w + on_bus.sh * (256 - w)) >> WEIGHT_SHIFT;
					end else begin
						// partial block: pass the source byte through
						mix = on_bus.src;
					end
					res.pix = PIX_BITS'(mix);
					res.eop = eop;
					blend_expect_q.push_back(res);
					blend_pos = nxt;
				end
			end
			if (s_tvalid && !s_tready) begin
				// hold the current transfer
			end else if (send_gap != 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (feed_q.size() != 0 &&
					!(feed_q[0].hold_for_drain && blend_expect_q.size() != 0)) begin
				on_bus = feed_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {3'b000, on_bus.sh, on_bus.src, on_bus.wv, on_bus.idx};
				s_tuser <= on_bus.cmd;
				send_gap = idle_en ? draw_gap() : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: compare every result transfer with the oldest expectation and
	// stall the master stream at random while idling is on.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : result_monitor
		blend_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (blend_expect_q.size() == 0) begin
					flag_error($sformatf("unexpected result: pixel %0d last %0b", m_tdata, m_tlast));
				end else begin
					want = blend_expect_q.pop_front();
					if (m_tdata !== want.pix || m_tlast !== want.eop)
						flag_error($sformatf("pixel %0d last %0b, expected pixel %0d last %0b",
							m_tdata, m_tlast, want.pix, want.eop));
				end
			end
			if (sink_stall != 0) begin
				sink_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (idle_en && $urandom_range(0, 2) == 0) sink_stall = draw_gap();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus: directed corner items at the reset geometry, the extreme
	// geometries, then random phases. Sizes change only with the stream idle,
	// and the raster position carries over, so a change can land mid-plane.
	// ------------------------------------------------------------------------
	initial begin
		int unsigned n, hold_at;
		cur_sizes.bw = 7'd8;
		cur_sizes.bh = 7'd8;
		cur_sizes.lw = 13'd720;
		cur_sizes.lc = 13'd576;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// weights at the extremes, saturation, highest table index
		queue_load(12'd0, 9'd0, 1'b0);
		queue_load(12'd1, WEIGHT_ONE, 1'b0);
		queue_load(12'd2, 9'd257, 1'b0);
		queue_load(12'd3, 9'h1FF, 1'b0);
		queue_load(12'd4, 9'd128, 1'b0);
		queue_load(12'd5, 9'd1, 1'b0);
		queue_load(12'd6, 9'd255, 1'b0);
		queue_load(12'd7, 9'd64, 1'b0);
		queue_load(12'hFFF, 9'd300, 1'b0);
		// pixel extremes across the first block and into the next
		queue_blend(8'd255, 8'd0, 1'b0);
		queue_blend(8'd0, 8'd255, 1'b0);
		queue_blend(8'd255, 8'd255, 1'b0);
		queue_blend(8'd0, 8'd0, 1'b0);
		queue_blend(8'd128, 8'd77, 1'b0);
		queue_blend(8'd1, 8'd254, 1'b0);
		queue_blend(8'd200, 8'd3, 1'b0);
		queue_blend(8'd33, 8'd99, 1'b0);
		queue_blend(8'd255, 8'd0, 1'b0);
		queue_blend(8'd0, 8'd255, 1'b0);
		// a load right before the blend that reads the same entry
		queue_load(12'd2, 9'd200, 1'b0);
		queue_blend(8'd10, 8'd250, 1'b0);
		wait_drained();

		// writes to indexes beyond the register list change nothing
		write_reg(REG_SPARE_FIRST, 13'h1FFF);
		write_reg(REG_SPARE_LAST, 13'h0001);

		// tallest plane: zero line width acts as one, line count above the bound
		idle_en = 1'b0;
		set_sizes(13'd1, 13'd64, 13'd0, 13'h1FFF);
		repeat (150) queue_blend(PIX_BITS'($urandom), PIX_BITS'($urandom), 1'b0);
		wait_drained();

		// widest plane: block width with dropped upper bits, zero block height
		set_sizes(13'h1FC0, 13'd0, 13'h1FFF, 13'd1);
		repeat (150) queue_blend(PIX_BITS'($urandom), PIX_BITS'($urandom), 1'b0);
		wait_drained();

		// block wider than the plane: everything passes through
		idle_en = 1'b1;
		set_sizes(13'd127, 13'd3, 13'd20, 13'd5);
		repeat (100) queue_blend(PIX_BITS'($urandom), PIX_BITS'($urandom), 1'b0);
		wait_drained();

		// random geometries, mostly pixel pairs with some weight reloads;
		// one item per phase waits until all results are in
		for (int ph = 0; ph < 10; ph++) begin
			idle_en = (ph == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
			set_sizes(draw_block_size(), draw_block_size(), draw_line_size(40), draw_line_size(20));
			n = $urandom_range(40, 80);
			hold_at = $urandom_range(10, n - 10);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 6) == 0)
					queue_load(IDX_BITS'($urandom), draw_weight(), k == hold_at);
				else
					queue_blend(PIX_BITS'($urandom), PIX_BITS'($urandom), k == hold_at);
			end
			wait_drained();
		end

		if (blend_expect_q.size() != 0)
			flag_error($sformatf("%0d results never arrived", blend_expect_q.size()));
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
